// ===== hdl/sopsc_pkg.sv =====
package sopsc_pkg;

    // default memory sizes
    localparam int SEG_BITS_DEF  = 524288;
    localparam int ROOT_BITS_DEF = 512;

    // field widths
    localparam int LIMIT_W = 21;
    localparam int PI_W    = 6;
    localparam int PC_W    = 7;
    localparam int CNT_W   = 20;
    localparam int ERR_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 21'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 21'd1048576;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PARTS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INDEX = 2'd2;

    // internal widths
    localparam int M_W    = 20;          // n - 2
    localparam int ROOT_W = 11;          // isqrt(n) and sieving prime
    localparam int PP_W   = 2 * ROOT_W;  // prime squared
    localparam int RSZ_W  = 10;          // root bitmap length and index
    localparam int IDX_W  = 21;          // segment index incl. overshoot

    // shared divider
    localparam int DIV_NW = 27;
    localparam int DIV_DW = 11;
    localparam int DIV_CW = $clog2(DIV_NW);

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/sopsc_ram.sv =====
module sopsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sopsc_div.sv =====
module sopsc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sopsc_pkg::t_div_req i_req,
    output sopsc_pkg::t_div_rsp o_rsp
);

    localparam int NW = sopsc_pkg::DIV_NW;
    localparam int DW = sopsc_pkg::DIV_DW;
    localparam int CW = sopsc_pkg::DIV_CW;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvs, n_dvs;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // one restoring step a cycle, msb first
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[NW-2:0], w_ge};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_pulse : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    a_busy_ends_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !n_busy |=> r_done)
        else $error("divider left busy without done");

endmodule

// ===== hdl/segmented_odd_prime_sieve_counter.sv =====
// segmented odd-only sieve: counts the odd primes in one part of 3..limit
//
// configuration: i_cfg_we/i_cfg_wdata load the 21-bit limit (reset value 100);
// write it only while the block is idle with no word outstanding
// input channel: i_in_valid with i_part_index/i_part_count, held by o_in_stall;
// a word is taken when valid is high and stall is low
// output channel: o_out_valid with o_prime_count/o_error, held by i_out_stall
//
// one word is worked on at a time; o_in_stall stays high until its result
// has gone into the output register, which is held while the receiver stalls
// work per word: 11 root steps, 3 divides, a clear sweep, a read of each root
// entry visited, per sieving prime the marking of its multiples (plus one more
// divide when the first multiple comes from lo mod p), and a count over the
// segment; marking writes one segment entry a cycle
// index errors go straight to the result, too-many-parts after the first divide
// reset clears the control state and sets limit to 100; the bitmaps are
// swept clear over the longer of the segment and root lengths before sieving
module segmented_odd_prime_sieve_counter #(
    parameter int SEG_BITS  = sopsc_pkg::SEG_BITS_DEF,
    parameter int ROOT_BITS = sopsc_pkg::ROOT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [sopsc_pkg::LIMIT_W-1:0] i_cfg_wdata,
    // request words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sopsc_pkg::PI_W-1:0]    i_part_index,
    input  logic [sopsc_pkg::PC_W-1:0]    i_part_count,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sopsc_pkg::CNT_W-1:0]   o_prime_count,
    output logic [sopsc_pkg::ERR_W-1:0]   o_error
);

    localparam int LW   = sopsc_pkg::LIMIT_W;
    localparam int PIW  = sopsc_pkg::PI_W;
    localparam int PCW  = sopsc_pkg::PC_W;
    localparam int CW   = sopsc_pkg::CNT_W;
    localparam int EW   = sopsc_pkg::ERR_W;
    localparam int MW   = sopsc_pkg::M_W;
    localparam int SW   = sopsc_pkg::ROOT_W;
    localparam int PPW  = sopsc_pkg::PP_W;
    localparam int RW   = sopsc_pkg::RSZ_W;
    localparam int IW   = sopsc_pkg::IDX_W;
    localparam int NW   = sopsc_pkg::DIV_NW;
    localparam int NW1  = sopsc_pkg::DIV_NW + 1;
    localparam int DW   = sopsc_pkg::DIV_DW;

    localparam int SEG_AW  = $clog2(SEG_BITS);
    localparam int ROOT_AW = $clog2(ROOT_BITS);

    // segment and root lengths are clipped to the memory sizes
    localparam logic [IW-1:0] SEG_CAP =
        (SEG_BITS >= (1 << IW)) ? {IW{1'b1}} : IW'(SEG_BITS);
    localparam logic [RW-1:0] ROOT_CAP =
        (ROOT_BITS >= (1 << RW)) ? {RW{1'b1}} : RW'(ROOT_BITS);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_SQRT      = 16'h0002,
        S_DIV_CHK   = 16'h0004,
        S_DIV_LO    = 16'h0008,
        S_DIV_HI    = 16'h0010,
        S_SIZE      = 16'h0020,
        S_CLEAR     = 16'h0040,
        S_RD_ROOT   = 16'h0080,
        S_CHK_ROOT  = 16'h0100,
        S_PRIME     = 16'h0200,
        S_ROOT_MARK = 16'h0400,
        S_SEG_FIRST = 16'h0800,
        S_SEG_DIV   = 16'h1000,
        S_SEG_MARK  = 16'h2000,
        S_COUNT     = 16'h4000,
        S_RESULT    = 16'h8000
    } t_state;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_limit;
    logic [PIW-1:0]  r_pi, n_pi;
    logic [PCW-1:0]  r_pc, n_pc;
    logic [LW-1:0]   r_n, n_n;
    logic [MW-1:0]   r_m, n_m;
    logic [SW-1:0]   r_root, n_root;
    logic [SW-1:0]   r_sqbit, n_sqbit;
    logic            r_dwait, n_dwait;
    logic [MW-1:0]   r_bl, n_bl;
    logic [MW-1:0]   r_bn, n_bn;
    logic [LW-1:0]   r_lo, n_lo;
    logic [IW-1:0]   r_size, n_size;
    logic [RW-1:0]   r_rsize, n_rsize;
    logic [RW-1:0]   r_k, n_k;
    logic [SW-1:0]   r_p, n_p;
    logic [PPW-1:0]  r_pp, n_pp;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_rdv, n_rdv;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [EW-1:0]   r_err, n_err;
    logic            r_out_valid, n_out_valid;
    logic [CW-1:0]   r_out_count, n_out_count;
    logic [EW-1:0]   r_out_err, n_out_err;

    sopsc_pkg::t_div_req div_req;
    sopsc_pkg::t_div_rsp div_rsp;

    logic            seg_we, seg_wdata, seg_rdata;
    logic            root_we, root_wdata, root_rdata;

    logic            w_in_acc;
    logic [LW-1:0]   w_nsat;
    logic [SW-1:0]   w_try;
    logic [PPW-1:0]  w_sq;
    logic [PCW-1:0]  w_pi1;
    logic [NW-1:0]   w_prod_lo, w_prod_hi;
    logic [NW1-1:0]  w_chk;
    logic [MW-1:0]   w_bh;
    logic [LW-1:0]   w_lo, w_hi, w_span;
    logic [IW-1:0]   w_size_nat, w_size;
    logic [SW-1:0]   w_rspan;
    logic [RW-1:0]   w_rsize_nat, w_rsize;
    logic [SW-1:0]   w_p;
    logic [PPW-1:0]  w_pp;
    logic [PPW-1:0]  w_pdiff;
    logic [PPW-1:0]  w_pp3;
    logic [DW-1:0]   w_rem;
    logic [IW-1:0]   w_first_div;
    logic [IW-1:0]   w_idx_step, w_idx1;
    logic [RW-1:0]   w_k1;
    logic            w_klast;
    logic            w_seg_in, w_root_in;
    logic            w_out_free;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // limit saturates at the top of the range
    assign w_nsat = (r_limit > sopsc_pkg::LIMIT_MAX) ? sopsc_pkg::LIMIT_MAX : r_limit;

    // integer square root, one result bit per cycle
    assign w_try = r_root | r_sqbit;
    assign w_sq  = PPW'(w_try) * PPW'(w_try);

    // block bounds: pi*m/pc and (pi+1)*m/pc
    assign w_pi1     = {1'b0, r_pi} + PCW'(1);
    assign w_prod_lo = NW'(r_pi) * NW'(r_m);
    assign w_prod_hi = NW'(w_pi1) * NW'(r_m);

    // too-many-parts test: 3 + m/(2P) < isqrt(n)
    assign w_chk = NW1'(div_rsp.quot) + NW1'(3);

    // odd range of the part and its length in entries
    assign w_bh   = r_bn - MW'(1);
    assign w_lo   = LW'(r_bl) + LW'(r_bl[0]) + LW'(3);
    assign w_hi   = LW'(w_bh) - LW'(w_bh[0]) + LW'(3);
    assign w_span = w_hi - w_lo;

    always_comb begin
        if ((r_bn > r_bl) && (w_hi >= w_lo)) begin
            w_size_nat = IW'(w_span >> 1) + IW'(1);
        end else begin
            w_size_nat = '0;
        end
        w_size = (w_size_nat > SEG_CAP) ? SEG_CAP : w_size_nat;
    end

    // root bitmap covers the odd numbers 3..isqrt(n)
    assign w_rspan = r_root - SW'(3);

    always_comb begin
        if (r_root >= SW'(3)) begin
            w_rsize_nat = RW'(w_rspan >> 1) + RW'(1);
        end else begin
            w_rsize_nat = '0;
        end
        w_rsize = (w_rsize_nat > ROOT_CAP) ? ROOT_CAP : w_rsize_nat;
    end

    // candidate prime from the root index
    assign w_p  = {r_k, 1'b0} + SW'(3);
    assign w_pp = PPW'(w_p) * PPW'(w_p);

    assign w_pdiff = r_pp - PPW'(r_lo);
    assign w_pp3   = r_pp - PPW'(3);

    // first odd multiple of p at or above lo, from lo mod p
    assign w_rem = div_rsp.rem;

    always_comb begin
        if (w_rem == '0) begin
            w_first_div = '0;
        end else if (w_rem[0]) begin
            w_first_div = IW'((r_p - w_rem) >> 1);
        end else begin
            w_first_div = IW'(r_p - (w_rem >> 1));
        end
    end

    assign w_idx_step = r_idx + IW'(r_p);
    assign w_idx1     = r_idx + IW'(1);
    assign w_k1       = r_k + RW'(1);
    assign w_klast    = (w_k1 == r_rsize);
    assign w_seg_in   = r_idx < r_size;
    assign w_root_in  = r_idx < IW'(r_rsize);

    always_comb begin
        n_state     = r_state;
        n_pi        = r_pi;
        n_pc        = r_pc;
        n_n         = r_n;
        n_m         = r_m;
        n_root      = r_root;
        n_sqbit     = r_sqbit;
        n_dwait     = r_dwait;
        n_bl        = r_bl;
        n_bn        = r_bn;
        n_lo        = r_lo;
        n_size      = r_size;
        n_rsize     = r_rsize;
        n_k         = r_k;
        n_p         = r_p;
        n_pp        = r_pp;
        n_idx       = r_idx;
        n_rdv       = r_rdv;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        div_req     = '0;
        seg_we      = 1'b0;
        root_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_pi    = i_part_index;
                    n_pc    = i_part_count;
                    n_n     = w_nsat;
                    n_m     = MW'(w_nsat - LW'(2));
                    n_cnt   = '0;
                    n_err   = sopsc_pkg::ERR_OK;
                    n_root  = '0;
                    n_sqbit = {1'b1, {(SW-1){1'b0}}};
                    n_dwait = 1'b0;
                    if ((i_part_count == '0) || ({1'b0, i_part_index} >= i_part_count)) begin
                        n_err   = sopsc_pkg::ERR_INDEX;
                        n_state = S_RESULT;
                    end else if (w_nsat < LW'(3)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SQRT;
                    end
                end
            end

            S_SQRT: begin
                if (w_sq <= PPW'(r_n)) begin
                    n_root = w_try;
                end
                n_sqbit = r_sqbit >> 1;
                if (r_sqbit[0]) begin
                    n_state = S_DIV_CHK;
                end
            end

            S_DIV_CHK: begin
                div_req.dividend = NW'(r_m);
                div_req.divisor  = DW'({r_pc, 1'b0});
                if (!r_dwait) begin
                    div_req.start = 1'b1;
                    n_dwait       = 1'b1;
                end else if (div_rsp.done) begin
                    n_dwait = 1'b0;
                    if (w_chk < NW1'(r_root)) begin
                        n_err   = sopsc_pkg::ERR_PARTS;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_DIV_LO;
                    end
                end
            end

            S_DIV_LO: begin
                div_req.dividend = w_prod_lo;
                div_req.divisor  = DW'(r_pc);
                if (!r_dwait) begin
                    div_req.start = 1'b1;
                    n_dwait       = 1'b1;
                end else if (div_rsp.done) begin
                    n_dwait = 1'b0;
                    n_bl    = div_rsp.quot[MW-1:0];
                    n_state = S_DIV_HI;
                end
            end

            S_DIV_HI: begin
                div_req.dividend = w_prod_hi;
                div_req.divisor  = DW'(r_pc);
                if (!r_dwait) begin
                    div_req.start = 1'b1;
                    n_dwait       = 1'b1;
                end else if (div_rsp.done) begin
                    n_dwait = 1'b0;
                    n_bn    = div_rsp.quot[MW-1:0];
                    n_state = S_SIZE;
                end
            end

            S_SIZE: begin
                n_lo    = w_lo;
                n_size  = w_size;
                n_rsize = w_rsize;
                n_idx   = '0;
                // an empty part counts nothing, no sieving needed
                if (w_size == '0) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_CLEAR;
                end
            end

            S_CLEAR: begin
                seg_we  = w_seg_in;
                root_we = w_root_in;
                n_idx   = w_idx1;
                if ((w_idx1 >= r_size) && (w_idx1 >= IW'(r_rsize))) begin
                    n_k = '0;
                    if (r_rsize == '0) begin
                        n_idx   = '0;
                        n_rdv   = 1'b0;
                        n_state = S_COUNT;
                    end else begin
                        n_state = S_RD_ROOT;
                    end
                end
            end

            S_RD_ROOT: begin
                n_state = S_CHK_ROOT;
            end

            S_CHK_ROOT: begin
                if (root_rdata) begin
                    n_k = w_k1;
                    if (w_klast) begin
                        n_idx   = '0;
                        n_rdv   = 1'b0;
                        n_state = S_COUNT;
                    end else begin
                        n_state = S_RD_ROOT;
                    end
                end else begin
                    n_p     = w_p;
                    n_pp    = w_pp;
                    n_state = S_PRIME;
                end
            end

            S_PRIME: begin
                if (r_pp > PPW'(r_n)) begin
                    n_idx   = '0;
                    n_rdv   = 1'b0;
                    n_state = S_COUNT;
                end else begin
                    n_idx   = IW'(w_pp3 >> 1);
                    n_state = S_ROOT_MARK;
                end
            end

            S_ROOT_MARK: begin
                if (w_root_in) begin
                    root_we = 1'b1;
                    n_idx   = w_idx_step;
                end else begin
                    n_state = S_SEG_FIRST;
                end
            end

            S_SEG_FIRST: begin
                if (r_pp > PPW'(r_lo)) begin
                    n_idx   = IW'(w_pdiff >> 1);
                    n_state = S_SEG_MARK;
                end else begin
                    n_dwait = 1'b0;
                    n_state = S_SEG_DIV;
                end
            end

            S_SEG_DIV: begin
                div_req.dividend = NW'(r_lo);
                div_req.divisor  = DW'(r_p);
                if (!r_dwait) begin
                    div_req.start = 1'b1;
                    n_dwait       = 1'b1;
                end else if (div_rsp.done) begin
                    n_dwait = 1'b0;
                    n_idx   = w_first_div;
                    n_state = S_SEG_MARK;
                end
            end

            S_SEG_MARK: begin
                if (w_seg_in) begin
                    seg_we = 1'b1;
                    n_idx  = w_idx_step;
                end else begin
                    n_k = w_k1;
                    if (w_klast) begin
                        n_idx   = '0;
                        n_rdv   = 1'b0;
                        n_state = S_COUNT;
                    end else begin
                        n_state = S_RD_ROOT;
                    end
                end
            end

            S_COUNT: begin
                // the returned mark lags its read address by the RAM's output register
                if (w_seg_in) begin
                    n_rdv = 1'b1;
                    n_idx = w_idx1;
                end else begin
                    n_rdv = 1'b0;
                end
                if (r_rdv && !seg_rdata) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (!w_seg_in && !r_rdv) begin
                    n_state = S_RESULT;
                end
            end

            S_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_cnt;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign seg_wdata  = (r_state == S_SEG_MARK);
    assign root_wdata = (r_state == S_ROOT_MARK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= sopsc_pkg::LIMIT_RST;
            r_dwait     <= 1'b0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dwait     <= n_dwait;
            r_rdv       <= n_rdv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
        r_pi        <= n_pi;
        r_pc        <= n_pc;
        r_n         <= n_n;
        r_m         <= n_m;
        r_root      <= n_root;
        r_sqbit     <= n_sqbit;
        r_bl        <= n_bl;
        r_bn        <= n_bn;
        r_lo        <= n_lo;
        r_size      <= n_size;
        r_rsize     <= n_rsize;
        r_k         <= n_k;
        r_p         <= n_p;
        r_pp        <= n_pp;
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_err       <= n_err;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    sopsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // segment bitmap: cleared, marked and counted through one port pair
    sopsc_ram #(
        .WIDTH (1),
        .DEPTH (SEG_BITS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (SEG_AW'(r_idx)),
        .i_wdata (seg_wdata),
        .i_raddr (SEG_AW'(r_idx)),
        .o_rdata (seg_rdata)
    );

    // root bitmap: cleared, read at the candidate, written at its multiples
    sopsc_ram #(
        .WIDTH (1),
        .DEPTH (ROOT_BITS)
    ) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (root_we),
        .i_waddr (ROOT_AW'(r_idx)),
        .i_wdata (root_wdata),
        .i_raddr (ROOT_AW'(r_k)),
        .o_rdata (root_rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_prime_count = r_out_count;
    assign o_error       = r_out_err;

    a_err_zero_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error != sopsc_pkg::ERR_OK) |-> o_prime_count == '0)
        else $error("nonzero count on an error word");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> IW'(r_cnt) <= r_size)
        else $error("count exceeds segment length");

    a_root_ahead : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT_MARK) && w_root_in |-> r_idx > IW'(r_k))
        else $error("root marking reached an entry already visited");

endmodule

// ===== test/segmented_odd_prime_sieve_counter_tb.sv =====
module segmented_odd_prime_sieve_counter_tb;

    import sopsc_pkg::*;

    // no handshake of any kind for this many cycles ends the run
    // (slowest word here is the largest limit split in 16 parts)
    localparam int WATCHDOG_CYCLES = 2000000;
    // settle time after the last awaited word has come back
    localparam int TAIL_CYCLES     = 200;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 20;

    typedef struct packed {
        logic [CNT_W-1:0] primes;
        logic [ERR_W-1:0] err;
    } tally_t;

    // keeps its own copy of the limit, works out the count for each request
    // word taken and matches the result words against them in order
    class odd_prime_tally;
        logic [LIMIT_W-1:0] limit_val;
        tally_t             awaited[$];
        int                 failures;
        bit                 seg_mark [SEG_BITS_DEF];
        bit                 root_mark [ROOT_BITS_DEF];

        function new();
            limit_val = LIMIT_RST;
            failures  = 0;
        endfunction

        function void load_limit(logic [LIMIT_W-1:0] value);
            limit_val = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // segment offset of the first odd multiple of p at or above lo
        function longint unsigned first_mark(longint unsigned p, longint unsigned lo);
            longint unsigned r;
            if (p * p > lo)
                return (p * p - lo) / 2;
            r = lo % p;
            if (r == 0)
                return 0;
            if (r[0])
                return (p - r) / 2;
            return p - r / 2;
        endfunction

        function tally_t count_part(logic [PI_W-1:0] pi, logic [PC_W-1:0] pc);
            tally_t          res;
            longint unsigned n, m, s, bl, bn, bh, lo, hi, size, rsize, p, i, k, pil, pcl;
            int unsigned     cnt;
            bit              stop;
            res.primes = '0;
            res.err    = ERR_OK;
            pil = 64'(pi);
            pcl = 64'(pc);
            if (pcl == 0 || pil >= pcl) begin
                res.err = ERR_INDEX;
                return res;
            end
            n = 64'(limit_val);
            if (n > 64'(LIMIT_MAX))
                n = 64'(LIMIT_MAX);
            if (n < 3)
                return res;
            m = n - 2;
            s = 0;
            while ((s + 1) * (s + 1) <= n)
                s++;
            if (3 + m / (2 * pcl) < s) begin
                res.err = ERR_PARTS;
                return res;
            end
            // odd bounds of this block
            lo   = 3;
            size = 0;
            bl   = pil * m / pcl;
            bn   = (pil + 1) * m / pcl;
            if (bn > bl) begin
                bh = bn - 1;
                lo = 3 + bl + (bl & 1);
                hi = 3 + bh - (bh & 1);
                if (hi >= lo)
                    size = (hi - lo) / 2 + 1;
            end
            if (size > 64'(SEG_BITS_DEF))
                size = 64'(SEG_BITS_DEF);
            rsize = (s >= 3) ? (s - 3) / 2 + 1 : 0;
            if (rsize > 64'(ROOT_BITS_DEF))
                rsize = 64'(ROOT_BITS_DEF);
            for (i = 0; i < size; i++)
                seg_mark[i] = 1'b0;
            for (i = 0; i < 64'(ROOT_BITS_DEF); i++)
                root_mark[i] = 1'b0;
            stop = 1'b0;
            for (k = 0; k < rsize && !stop; k++) begin
                if (!root_mark[k]) begin
                    p = 2 * k + 3;
                    if (p * p > n) begin
                        stop = 1'b1;
                    end else begin
                        for (i = (p * p - 3) / 2; i < rsize; i += p)
                            root_mark[i] = 1'b1;
                        for (i = first_mark(p, lo); i < size; i += p)
                            seg_mark[i] = 1'b1;
                    end
                end
            end
            cnt = 0;
            for (i = 0; i < size; i++)
                if (!seg_mark[i])
                    cnt++;
            res.primes = cnt[CNT_W-1:0];
            return res;
        endfunction

        function void note_request(logic [PI_W-1:0] pi, logic [PC_W-1:0] pc);
            awaited.push_back(count_part(pi, pc));
        endfunction

        function void check_result(logic [CNT_W-1:0] primes, logic [ERR_W-1:0] err);
            tally_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result word with none awaited: prime_count %0d error %0d",
                         $time, primes, err);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (primes !== want.primes) begin
                $display("%0t: prime_count mismatch: expected %0d actual %0d",
                         $time, want.primes, primes);
                failures++;
            end
            if (err !== want.err) begin
                $display("%0t: error mismatch: expected %0d actual %0d",
                         $time, want.err, err);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [PI_W-1:0]    i_part_index;
    logic [PC_W-1:0]    i_part_count;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CNT_W-1:0]   o_prime_count;
    logic [ERR_W-1:0]   o_error;

    odd_prime_tally tally;
    bit             calm = 1'b0;   // no gaps on either side while set
    int             stall_left = 0;
    int             quiet_cycles = 0;

    segmented_odd_prime_sieve_counter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_part_index  (i_part_index),
        .i_part_count  (i_part_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_prime_count (o_prime_count),
        .o_error       (o_error)
    );

    always #2 i_clk = ~i_clk;

    // mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small limits keep each word short;
    // a tenth of the phases fall below three where the range is empty
    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return LIMIT_W'($urandom_range(0, 2));
        if (r < 25)
            return LIMIT_W'($urandom_range(3, 60));
        return LIMIT_W'($urandom_range(61, 2500));
    endfunction

    // receiver side: stalls of random length, none while calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!calm)
                stall_left <= pick_gap();
        end
    end

    // watch both channels and the limit register at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                tally.load_limit(i_cfg_wdata);
            if (i_in_valid && !o_in_stall)
                tally.note_request(i_part_index, i_part_count);
            if (o_out_valid && !i_out_stall)
                tally.check_result(o_prime_count, o_error);
        end
    end

    // counts cycles with no word moving on either side and no limit write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one request word, holding it until taken; valid is only lowered
    // for a gap or a drain, so a back-to-back word keeps it high
    task automatic send_request(input logic [PI_W-1:0] pi, input logic [PC_W-1:0] pc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_part_index <= pi;
        i_part_count <= pc;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // hold off the sender until every awaited word has come back;
    // the wait always passes a clock edge, so valid is never dropped and raised together
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tally.pending() != 0);
    endtask

    // every word gives a result, so once drained the block is idle
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly well-formed parts, some oversized part counts, some raw noise
    task automatic random_request();
        int               r;
        logic [PC_W-1:0]  pc;
        logic [PI_W-1:0]  pi;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            pc = (r < 40) ? PC_W'($urandom_range(1, 8)) : PC_W'($urandom_range(1, 64));
            pi = PI_W'($urandom_range(0, int'(pc) - 1));
        end else if (r < 88) begin
            pc = PC_W'($urandom_range(65, 127));
            pi = PI_W'($urandom);
        end else begin
            pc = PC_W'($urandom);
            pi = PI_W'($urandom);
        end
        send_request(pi, pc);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_part_index = '0;
        i_part_count = '0;
        tally        = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit of 100: whole range, bad indices, too many parts,
        // and a three-way split
        send_request(0, 1);
        send_request(0, 0);
        send_request(1, 1);
        send_request(63, 64);
        send_request(0, 3);
        send_request(1, 3);
        send_request(2, 3);

        // limits below three give an empty range
        write_limit(0);
        send_request(0, 1);
        write_limit(1);
        send_request(0, 1);
        write_limit(2);
        send_request(0, 2);

        // limit three: no sieving primes; the whole range holds 3, the first of two parts nothing
        write_limit(3);
        send_request(0, 1);
        send_request(0, 2);

        // all ones saturates to the largest limit; wide splits keep it short
        write_limit('1);
        send_request(63, 64);
        send_request(0, 64);
        send_request(63, 127);
        send_request(5, 0);

        // largest limit written directly, last of sixteen parts
        write_limit(LIMIT_MAX);
        send_request(15, 16);

        // mid-sized limit where too many parts trips
        write_limit(1000);
        send_request(0, 64);
        send_request(9, 10);
        send_request(0, 127);

        // random phases, each at a fresh limit; one runs with no gaps at all,
        // and each pauses halfway until every result is back
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            calm = (ph == 2);
            write_limit(pick_limit());
            for (int j = 0; j < WORDS_PER_PHASE; j++) begin
                if (j == WORDS_PER_PHASE / 2)
                    drain();
                random_request();
            end
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tally.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
